[hdl/radix_string_to_int128_assert.svh]
// assertion macros for the radix string parser
// used by modules with an aclk clock and an aresetn active-low reset in scope
`ifndef RADIX_STRING_TO_INT128_ASSERT_SVH
`define RADIX_STRING_TO_INT128_ASSERT_SVH
`ifndef SYNTHESIS
`define RSI_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("radix_string_to_int128: invariant violated");
`define RSI_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("radix_string_to_int128: implication violated");
`else
`define RSI_ASSERT_ALWAYS(label, expr)
`define RSI_ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

[hdl/rsi_pkg.sv]
// shared types, constants and helpers for the radix string parser
// no dependencies
package rsi_pkg;

    localparam int ACC_W       = 128;
    localparam int HALF_W      = 64;
    localparam int DIGIT_W     = 5;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] MAX_DIGITS  = 10'd512;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [DIGIT_W-1:0] DIGIT_BAD   = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;

    typedef struct packed {
        logic                is_end;
        logic                is_sign;
        logic                is_minus;
        logic [DIGIT_W-1:0]  digit;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    function automatic logic [DIGIT_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = {3'b000, DIGIT_BAD};
        if (c >= CHAR_0 && c <= CHAR_9) begin
            v = c - CHAR_0;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            v = c - CHAR_LA + 8'd10;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            v = c - CHAR_UA + 8'd10;
        end
        return v[DIGIT_W-1:0];
    endfunction

    function automatic logic radix_valid(input logic [RADIX_W-1:0] r);
        return (r >= RADIX_MIN) && (r <= RADIX_MAX);
    endfunction

endpackage

[hdl/rsi_front.sv]
// front end: accepts characters and end markers and classifies them
// depends on rsi_pkg
module rsi_front (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rsi_pkg::CHAR_W-1:0]  s_character,
    input  logic                        s_end_marker,
    input  logic                        q_full,
    output rsi_pkg::push_t              push
);
    import rsi_pkg::*;

    assign s_ready = !q_full;

    always_comb begin
        push.valid         = s_valid && !q_full;
        push.item.is_end   = s_end_marker;
        push.item.is_sign  = (s_character == CHAR_MINUS) || (s_character == CHAR_PLUS);
        push.item.is_minus = (s_character == CHAR_MINUS);
        push.item.digit    = hex_value(s_character);
    end

endmodule

[hdl/rsi_queue.sv]
// short queue of classified items between front and back end
// depends on rsi_pkg and the assertion macro header
`include "radix_string_to_int128_assert.svh"
module rsi_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  rsi_pkg::push_t  push,
    output logic            q_full,
    output rsi_pkg::head_t  head,
    input  logic            pop
);
    import rsi_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !q_full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    `RSI_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH))
    `RSI_ASSERT_IMPLIES(a_pop_not_empty, pop, count_reg != '0)
    `RSI_ASSERT_IMPLIES(a_full_blocks_push, q_full, !do_push)

endmodule

[hdl/rsi_back.sv]
// back end: per-string state, 128-bit multiply-add and result register
// depends on rsi_pkg and the assertion macro header
`include "radix_string_to_int128_assert.svh"
module rsi_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rsi_pkg::RADIX_W-1:0]  radix,
    input  rsi_pkg::head_t               head,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic                         m_is_negative,
    output logic [rsi_pkg::HALF_W-1:0]   m_magnitude_low,
    output logic [rsi_pkg::HALF_W-1:0]   m_magnitude_high
);
    import rsi_pkg::*;

    localparam int PROD_W = ACC_W + RADIX_W;

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [COUNT_W-1:0] digit_total_reg, digit_total_next;
    logic               failed_reg, failed_next;
    logic               first_reg, first_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_ok_reg, m_neg_reg;
    logic [ACC_W-1:0]   m_mag_reg;
    logic [PROD_W-1:0]  prod;
    logic               rad_ok, good, take_end;

    assign rad_ok   = radix_valid(radix);
    assign pop      = head.valid && (!head.item.is_end || !m_valid_reg || m_ready);
    assign take_end = pop && head.item.is_end;
    assign good     = !failed_reg && rad_ok && (digit_total_reg != '0);
    assign prod     = {{RADIX_W{1'b0}}, acc_reg} * {{ACC_W{1'b0}}, radix}
                    + {{ACC_W{1'b0}}, head.item.digit};

    always_comb begin
        acc_next         = acc_reg;
        neg_next         = neg_reg;
        digit_total_next = digit_total_reg;
        failed_next      = failed_reg;
        first_next       = first_reg;
        if (take_end) begin
            acc_next         = '0;
            neg_next         = 1'b0;
            digit_total_next = '0;
            failed_next      = 1'b0;
            first_next       = 1'b1;
        end else if (pop) begin
            first_next = 1'b0;
            if (failed_reg) begin
                failed_next = 1'b1;
            end else if (!rad_ok) begin
                failed_next = 1'b1;
            end else if (first_reg && head.item.is_sign) begin
                neg_next = head.item.is_minus;
            end else if (digit_total_reg >= MAX_DIGITS) begin
                failed_next = 1'b1;
            end else begin
                digit_total_next = digit_total_reg + 1'b1;
                if (head.item.digit >= radix) begin
                    failed_next = 1'b1;
                end else if (prod[PROD_W-1:ACC_W] != '0) begin
                    failed_next = 1'b1;
                end else begin
                    acc_next = prod[ACC_W-1:0];
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (take_end) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            digit_total_reg <= '0;
            failed_reg      <= 1'b0;
            first_reg       <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            acc_reg         <= acc_next;
            neg_reg         <= neg_next;
            digit_total_reg <= digit_total_next;
            failed_reg      <= failed_next;
            first_reg       <= first_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_end) begin
            m_ok_reg  <= good;
            m_neg_reg <= good && neg_reg;
            m_mag_reg <= good ? acc_reg : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_ok             = m_ok_reg;
    assign m_is_negative    = m_neg_reg;
    assign m_magnitude_low  = m_mag_reg[HALF_W-1:0];
    assign m_magnitude_high = m_mag_reg[ACC_W-1:HALF_W];

    `RSI_ASSERT_ALWAYS(a_digit_limit, digit_total_reg <= MAX_DIGITS)
    `RSI_ASSERT_IMPLIES(a_no_end_while_stalled, m_valid_reg && !m_ready, !take_end)
    `RSI_ASSERT_IMPLIES(a_fail_zeroes, m_valid_reg && !m_ok_reg, !m_neg_reg && m_mag_reg == '0)

endmodule

[hdl/radix_string_to_int128.sv]
// top level of the streaming radix numeral parser
// depends on rsi_pkg, rsi_front, rsi_queue and rsi_back
//
// usage:
//   input channel s_*: one item per character (s_character) or an end marker
//   (s_end_marker high, s_character ignored). an optional leading '-' or '+'
//   sets the sign, later characters are hex digits below the radix.
//   result channel m_*: one item per end marker with m_ok, m_is_negative and
//   the 128-bit magnitude split into m_magnitude_low and m_magnitude_high;
//   on failure all value fields are zero.
//   cfg_wen / cfg_wdata write the radix (reset 10); write only while idle.
// timing:
//   one item per cycle sustained unless m_ready stalls a result. a two-entry
//   queue sits between classification and accumulation; the back end does
//   the 128-bit multiply-add combinationally and registers each result.
// reset: synchronous, active low; clears the string state, empties the queue
//   and drops m_valid. when m_ready stays low, characters keep flowing until
//   the next end marker reaches the back end, then the queue fills and
//   s_ready falls.
module radix_string_to_int128 (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [rsi_pkg::RADIX_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rsi_pkg::CHAR_W-1:0]   s_character,
    input  logic                         s_end_marker,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic                         m_is_negative,
    output logic [rsi_pkg::HALF_W-1:0]   m_magnitude_low,
    output logic [rsi_pkg::HALF_W-1:0]   m_magnitude_high
);
    import rsi_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic               q_full;
    logic               pop;
    push_t              push;
    head_t              head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wen) begin
            radix_reg <= cfg_wdata;
        end
    end

    rsi_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_character  (s_character),
        .s_end_marker (s_end_marker),
        .q_full       (q_full),
        .push         (push)
    );

    rsi_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .q_full  (q_full),
        .head    (head),
        .pop     (pop)
    );

    rsi_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .radix            (radix_reg),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_is_negative    (m_is_negative),
        .m_magnitude_low  (m_magnitude_low),
        .m_magnitude_high (m_magnitude_high)
    );

endmodule
